[hw/rtl/ctr_pkg.sv]
// ============================================================================
// ctr_pkg - shared constants for the color temperature to RGB pipeline
// Fixed-point fit coefficients, stage counts and the ln(100) constant.
// ============================================================================
package ctr_pkg;

    // output level width and full scale
    localparam int LEVEL_BITS = 12;
    localparam logic [LEVEL_BITS-1:0] LEVEL_FULL = {LEVEL_BITS{1'b1}};

    // input clamp and branch points, kelvin
    localparam logic [15:0] K_MIN     = 16'd1000;
    localparam logic [15:0] K_MAX     = 16'd40000;
    localparam logic [15:0] K_KNEE    = 16'd6600;
    localparam logic [15:0] K_BLUE_LO = 16'd1900;
    localparam logic [15:0] K_OFS_B   = 16'd1000;
    localparam logic [15:0] K_OFS_HI  = 16'd6000;

    // ln(2) in Q30
    localparam logic [29:0] LN2_Q30 = 30'd744261118;

    // fit coefficients in Q24; the low-branch offsets and ONE_Q48 are in Q48
    localparam logic signed [56:0] G_LO_MUL = 57'sd6544483;
    localparam logic signed [56:0] G_LO_OFS = 57'sd10600540 <<< 24;
    localparam logic signed [56:0] B_LO_MUL = 57'sd9113497;
    localparam logic signed [56:0] B_LO_OFS = 57'sd20069813 <<< 24;
    localparam logic [24:0] R_HI_MUL = 25'd21691870;
    localparam logic [21:0] R_HI_EXP = 22'd2234805;
    localparam logic [24:0] G_HI_MUL = 25'd18956423;
    localparam logic [21:0] G_HI_EXP = 22'd1266929;
    localparam logic signed [56:0] ONE_Q48 = 57'sd1 <<< 48;

    // stage counts
    localparam int LOG_STEPS  = 24;              // squaring rounds
    localparam int LOG_LAT    = LOG_STEPS + 2;   // normalize + rounds + ln scale
    localparam int EXP_TERMS  = 16;
    localparam int EXP_LAT    = 3 * EXP_TERMS;   // mult, reciprocal mult, fix-up
    localparam int DIV_LAT    = 31;              // one quotient bit per stage
    localparam int SIDE_DLY   = 1 + EXP_LAT + DIV_LAT;
    localparam int PIPE_DEPTH = 1 + LOG_LAT + 1 + SIDE_DLY + 3;

    // ln of a 16-bit integer in Q24, same rounding as the hardware unit
    function automatic logic [27:0] f_ln_q24(input logic [15:0] u);
        logic [3:0]  n;
        logic [63:0] x;
        logic [23:0] frac;
        logic [63:0] prod;
        n    = 4'd0;
        frac = 24'd0;
        for (int i = 0; i < 16; i++) begin
            if (u[i]) begin
                n = 4'(i);
            end
        end
        x = 64'(u) << (5'd30 - 5'(n));
        for (int i = 0; i < LOG_STEPS; i++) begin
            x    = (x * x) >> 30;
            frac = {frac[22:0], 1'b0};
            if (x >= (64'd2 << 30)) begin
                x       = x >> 1;
                frac[0] = 1'b1;
            end
        end
        prod = 64'({n, frac}) * 64'(LN2_Q30);
        return prod[57:30];
    endfunction

    localparam logic [27:0] LN100_Q24 = f_ln_q24(16'd100);

endpackage

[hw/rtl/ctr_if.sv]
// ============================================================================
// ctr_if - stream channels of the color temperature to RGB block
// Valid/ready words: temperature in, three channel levels out.
// ============================================================================
interface ctr_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] temperature_kelvin;

    modport source (output valid, output temperature_kelvin, input ready);
    modport sink   (input valid, input temperature_kelvin, output ready);
endinterface

interface ctr_out_if;
    logic                            valid;
    logic                            ready;
    logic [ctr_pkg::LEVEL_BITS-1:0]  red_level;
    logic [ctr_pkg::LEVEL_BITS-1:0]  green_level;
    logic [ctr_pkg::LEVEL_BITS-1:0]  blue_level;

    modport source (output valid, output red_level, output green_level,
                    output blue_level, input ready);
    modport sink   (input valid, input red_level, input green_level,
                    input blue_level, output ready);
endinterface

[hw/rtl/color_temperature_to_rgb.sv]
// ============================================================================
// color_temperature_to_rgb - blackbody color temperature to RGB levels
// Throughput: one word per clock; the whole pipe holds when the output
//   register is full and not taken, so a stall drops and repeats nothing.
// Depth is set by the 24 squaring rounds of the log, the 16-term exp series
//   (3 stages a term) and the 31-stage bit-per-stage reciprocal divider.
// Reset (sync, active low) clears the valid bits only; data regs do not reset.
// ============================================================================
module color_temperature_to_rgb (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ctr_in_if.sink    i_temp,
    ctr_out_if.source o_rgb
);

    localparam int LB = ctr_pkg::LEVEL_BITS;
    localparam int NT = ctr_pkg::EXP_TERMS;
    localparam int ND = ctr_pkg::DIV_LAT;
    localparam int SD = ctr_pkg::SIDE_DLY;

    // ------------------------------------------------------------------
    // Global advance: every stage moves together unless the output word
    // is held by the consumer.
    // ------------------------------------------------------------------
    logic                            adv;
    logic [ctr_pkg::PIPE_DEPTH-1:0]  r_vld;

    assign adv          = !r_vld[ctr_pkg::PIPE_DEPTH-1] || o_rgb.ready;
    assign i_temp.ready = adv;
    assign o_rgb.valid  = r_vld[ctr_pkg::PIPE_DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[ctr_pkg::PIPE_DEPTH-2:0], i_temp.valid};
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: clamp, pick branch, form the two log arguments.
    // Low branch logs K and K-1000, high branch logs K-6000.
    // ------------------------------------------------------------------
    logic [15:0] n_k;
    logic        n_lo;
    logic        n_bz;
    logic [15:0] r_t0_ua;
    logic [15:0] r_t0_ub;
    logic        r_t0_lo;
    logic        r_t0_bz;

    always_comb begin
        n_k = i_temp.temperature_kelvin;
        if (n_k < ctr_pkg::K_MIN) begin
            n_k = ctr_pkg::K_MIN;
        end
        if (n_k > ctr_pkg::K_MAX) begin
            n_k = ctr_pkg::K_MAX;
        end
        n_lo = (n_k <= ctr_pkg::K_KNEE);
        n_bz = (n_k <= ctr_pkg::K_BLUE_LO);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_t0_ua <= n_lo ? n_k : (n_k - ctr_pkg::K_OFS_HI);
            r_t0_ub <= n_k - ctr_pkg::K_OFS_B;
            r_t0_lo <= n_lo;
            r_t0_bz <= n_bz;
        end
    end

    // ------------------------------------------------------------------
    // Log units, with branch flags riding alongside.
    // ------------------------------------------------------------------
    logic [27:0] w_ln_a;
    logic [27:0] w_ln_b;
    logic        r_sb_lo [ctr_pkg::LOG_LAT];
    logic        r_sb_bz [ctr_pkg::LOG_LAT];

    ctr_log_pipe u_log_a (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_u   (r_t0_ua),
        .o_ln  (w_ln_a)
    );

    ctr_log_pipe u_log_b (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_u   (r_t0_ub),
        .o_ln  (w_ln_b)
    );

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sb_lo[0] <= r_t0_lo;
            r_sb_bz[0] <= r_t0_bz;
            for (int i = 1; i < ctr_pkg::LOG_LAT; i++) begin
                r_sb_lo[i] <= r_sb_lo[i-1];
                r_sb_bz[i] <= r_sb_bz[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // P1: ln(t) = ln(u) - ln(100), signed Q24.
    // ------------------------------------------------------------------
    logic signed [28:0] r_p1_la;
    logic signed [28:0] r_p1_lb;
    logic               r_p1_lo;
    logic               r_p1_bz;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p1_la <= $signed({1'b0, w_ln_a}) - $signed({1'b0, ctr_pkg::LN100_Q24});
            r_p1_lb <= $signed({1'b0, w_ln_b}) - $signed({1'b0, ctr_pkg::LN100_Q24});
            r_p1_lo <= r_sb_lo[ctr_pkg::LOG_LAT-1];
            r_p1_bz <= r_sb_bz[ctr_pkg::LOG_LAT-1];
        end
    end

    // low-branch operands wait here until the power path catches up
    logic               r_d_lo [SD];
    logic               r_d_bz [SD];
    logic signed [28:0] r_d_la [SD];
    logic signed [28:0] r_d_lb [SD];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_d_lo[0] <= r_p1_lo;
            r_d_bz[0] <= r_p1_bz;
            r_d_la[0] <= r_p1_la;
            r_d_lb[0] <= r_p1_lb;
            for (int i = 1; i < SD; i++) begin
                r_d_lo[i] <= r_d_lo[i-1];
                r_d_bz[i] <= r_d_bz[i-1];
                r_d_la[i] <= r_d_la[i-1];
                r_d_lb[i] <= r_d_lb[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Power path, channel 0 = red, 1 = green: x^-e = 1 / exp(e*ln x).
    // ------------------------------------------------------------------
    logic [27:0] n_l;
    assign n_l = r_p1_la[28] ? 28'd0 : r_p1_la[27:0];

    logic [29:0] r_z       [2];
    logic [30:0] r_ea_p    [2][NT];
    logic [29:0] r_ea_z    [2][NT];
    logic [31:0] r_ea_s    [2][NT];
    logic [64:0] r_eb_pm   [2][NT];
    logic [30:0] r_eb_p    [2][NT];
    logic [29:0] r_eb_z    [2][NT];
    logic [31:0] r_eb_s    [2][NT];
    logic [30:0] r_ec_term [2][NT];
    logic [29:0] r_ec_z    [2][NT];
    logic [31:0] r_ec_sum  [2][NT];
    logic [31:0] r_dv_r    [2][ND];
    logic [31:0] r_dv_d    [2][ND];
    logic [30:0] r_dv_q    [2][ND];

    for (genvar ch = 0; ch < 2; ch++) begin : g_ch
        logic [21:0] w_exp;
        logic [49:0] n_a_prod;

        assign w_exp    = (ch == 0) ? ctr_pkg::R_HI_EXP : ctr_pkg::G_HI_EXP;
        assign n_a_prod = 50'(w_exp) * 50'(n_l);

        // exponent a in Q24 (below 1), series argument in Q30
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_z[ch] <= {n_a_prod[47:24], 6'd0};
            end
        end

        // Taylor terms: term_k = floor(floor(term_{k-1} * z) / k)
        for (genvar j = 0; j < NT; j++) begin : g_term
            localparam logic [34:0] RCP_M = 35'((64'd1 << 34) / (j + 1));
            localparam logic [4:0]  DIV_K = 5'(j + 1);

            logic [30:0] w_t_in;
            logic [29:0] w_z_in;
            logic [31:0] w_s_in;
            logic [60:0] n_tz;
            logic [30:0] n_q0;
            logic [35:0] n_rem;
            logic [30:0] n_q;

            if (j == 0) begin : g_first
                assign w_t_in = 31'd1 << 30;
                assign w_z_in = r_z[ch];
                assign w_s_in = 32'd1 << 30;
            end else begin : g_next
                assign w_t_in = r_ec_term[ch][j-1];
                assign w_z_in = r_ec_z[ch][j-1];
                assign w_s_in = r_ec_sum[ch][j-1];
            end

            assign n_tz  = 61'(w_t_in) * 61'(w_z_in);
            // reciprocal estimate is exact or one low
            assign n_q0  = r_eb_pm[ch][j][64:34];
            assign n_rem = 36'(r_eb_p[ch][j]) - 36'(n_q0) * 36'(DIV_K);
            assign n_q   = (n_rem >= 36'(DIV_K)) ? (n_q0 + 31'd1) : n_q0;

            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_ea_p[ch][j]    <= n_tz[60:30];
                    r_ea_z[ch][j]    <= w_z_in;
                    r_ea_s[ch][j]    <= w_s_in;
                    r_eb_pm[ch][j]   <= 65'(r_ea_p[ch][j]) * 65'(RCP_M);
                    r_eb_p[ch][j]    <= r_ea_p[ch][j];
                    r_eb_z[ch][j]    <= r_ea_z[ch][j];
                    r_eb_s[ch][j]    <= r_ea_s[ch][j];
                    r_ec_term[ch][j] <= n_q;
                    r_ec_z[ch][j]    <= r_eb_z[ch][j];
                    r_ec_sum[ch][j]  <= r_eb_s[ch][j] + 32'(n_q);
                end
            end
        end

        // restoring divider: floor(2^60 / sum), sum in [2^30, 2^32)
        for (genvar i = 0; i < ND; i++) begin : g_div
            logic [31:0] w_r_in;
            logic [31:0] w_d_in;
            logic [30:0] w_q_in;
            logic [32:0] n_rs;

            if (i == 0) begin : g_first
                assign w_r_in = 32'd1 << 29;
                assign w_d_in = r_ec_sum[ch][NT-1];
                assign w_q_in = 31'd0;
            end else begin : g_next
                assign w_r_in = r_dv_r[ch][i-1];
                assign w_d_in = r_dv_d[ch][i-1];
                assign w_q_in = r_dv_q[ch][i-1];
            end

            assign n_rs = {w_r_in, 1'b0};

            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_dv_d[ch][i] <= w_d_in;
                    if (n_rs >= {1'b0, w_d_in}) begin
                        r_dv_r[ch][i] <= 32'(n_rs - {1'b0, w_d_in});
                        r_dv_q[ch][i] <= {w_q_in[29:0], 1'b1};
                    end else begin
                        r_dv_r[ch][i] <= n_rs[31:0];
                        r_dv_q[ch][i] <= {w_q_in[29:0], 1'b0};
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // PM: coefficient products, Q48, and per-channel branch select.
    // ------------------------------------------------------------------
    logic [55:0]        n_hi_r;
    logic [55:0]        n_hi_g;
    logic signed [56:0] n_lo_g;
    logic signed [56:0] n_lo_b;
    logic signed [56:0] r_pm_v [3];

    assign n_hi_r = 56'(ctr_pkg::R_HI_MUL) * 56'(r_dv_q[0][ND-1]);
    assign n_hi_g = 56'(ctr_pkg::G_HI_MUL) * 56'(r_dv_q[1][ND-1]);
    assign n_lo_g = 57'(r_d_la[SD-1]) * ctr_pkg::G_LO_MUL - ctr_pkg::G_LO_OFS;
    assign n_lo_b = 57'(r_d_lb[SD-1]) * ctr_pkg::B_LO_MUL - ctr_pkg::B_LO_OFS;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (r_d_lo[SD-1]) begin
                r_pm_v[0] <= ctr_pkg::ONE_Q48;
                r_pm_v[1] <= n_lo_g;
                r_pm_v[2] <= r_d_bz[SD-1] ? 57'sd0 : n_lo_b;
            end else begin
                r_pm_v[0] <= $signed({7'd0, n_hi_r[55:6]});
                r_pm_v[1] <= $signed({7'd0, n_hi_g[55:6]});
                r_pm_v[2] <= ctr_pkg::ONE_Q48;
            end
        end
    end

    // ------------------------------------------------------------------
    // LVa/LVb: clamp to 0..1, scale to full level with round to nearest.
    // ------------------------------------------------------------------
    logic          r_lv_le0 [3];
    logic          r_lv_ge1 [3];
    logic [31:0]   r_lv_v32 [3];
    logic [LB-1:0] r_out    [3];

    for (genvar c = 0; c < 3; c++) begin : g_lvl
        logic [32+LB-1:0] n_scl;
        assign n_scl = (32+LB)'(r_lv_v32[c]) * (32+LB)'(ctr_pkg::LEVEL_FULL)
                     + ((32+LB)'(1) << 31);

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_lv_le0[c] <= (r_pm_v[c] <= 57'sd0);
                r_lv_ge1[c] <= (r_pm_v[c] >= ctr_pkg::ONE_Q48);
                r_lv_v32[c] <= r_pm_v[c][47:16];
                if (r_lv_le0[c]) begin
                    r_out[c] <= '0;
                end else if (r_lv_ge1[c]) begin
                    r_out[c] <= ctr_pkg::LEVEL_FULL;
                end else begin
                    r_out[c] <= n_scl[32+LB-1:32];
                end
            end
        end
    end

    assign o_rgb.red_level   = r_out[0];
    assign o_rgb.green_level = r_out[1];
    assign o_rgb.blue_level  = r_out[2];

endmodule

[hw/rtl/ctr_log_pipe.sv]
// ============================================================================
// ctr_log_pipe - pipelined natural log of a 16-bit integer, Q24 result
// Normalize, 24 squaring rounds (one per stage), then scale by ln(2).
// ============================================================================
module ctr_log_pipe (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [15:0] i_u,
    output logic [27:0] o_ln
);

    logic [15:0] n_u;
    logic [3:0]  n_msb;
    logic [30:0] n_x0;

    logic [30:0] r_x    [ctr_pkg::LOG_STEPS+1];
    logic [23:0] r_frac [ctr_pkg::LOG_STEPS+1];
    logic [3:0]  r_n    [ctr_pkg::LOG_STEPS+1];
    logic [27:0] r_ln;
    logic [57:0] n_ln_prod;

    // zero reads as one
    always_comb begin
        n_u   = (i_u == 16'd0) ? 16'd1 : i_u;
        n_msb = 4'd0;
        for (int i = 0; i < 16; i++) begin
            if (n_u[i]) begin
                n_msb = 4'(i);
            end
        end
        n_x0 = 31'(n_u) << (5'd30 - 5'(n_msb));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= n_x0;
            r_frac[0] <= 24'd0;
            r_n[0]    <= n_msb;
        end
    end

    for (genvar s = 0; s < ctr_pkg::LOG_STEPS; s++) begin : g_sq
        logic [61:0] n_sq;
        assign n_sq = 62'(r_x[s]) * 62'(r_x[s]);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[s+1] <= r_n[s];
                if (n_sq[61]) begin
                    r_x[s+1]    <= n_sq[61:31];
                    r_frac[s+1] <= {r_frac[s][22:0], 1'b1};
                end else begin
                    r_x[s+1]    <= n_sq[60:30];
                    r_frac[s+1] <= {r_frac[s][22:0], 1'b0};
                end
            end
        end
    end

    assign n_ln_prod = 58'({r_n[ctr_pkg::LOG_STEPS], r_frac[ctr_pkg::LOG_STEPS]})
                     * 58'(ctr_pkg::LN2_Q30);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ln <= n_ln_prod[57:30];
        end
    end

    assign o_ln = r_ln;

endmodule
